// File: rtl/display_optics_composite_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the display optics composite
// Concurrent checks on clk_i with reset rst_ni; ASSERT_OFF removes them.
// ----------------------------------------------------------------------------
`ifndef DISPLAY_OPTICS_COMPOSITE_DEFINES_SVH
`define DISPLAY_OPTICS_COMPOSITE_DEFINES_SVH

`ifndef ASSERT_OFF
`define DOC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define DOC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define DOC_ASSERT(lbl, prop, msg)
`define DOC_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

// File: rtl/doc_pkg.sv
// ----------------------------------------------------------------------------
// doc_pkg
// Constants, register codes, stage payload types and helpers of the
// display optics composite.
// ----------------------------------------------------------------------------
package doc_pkg;

  localparam int MAX_DIM          = 4096;
  localparam int COLOR_FRAC_BITS  = 12;
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int GAIN_FRAC        = 12;
  localparam int SIN_IDX_W        = $clog2(SINE_TABLE_DEPTH);
  localparam int CW               = 24;   // internal color width
  localparam int NSTG             = 10;   // pipeline depth
  localparam int CFG_IDX_W        = 4;
  localparam int CFG_DATA_W       = 25;

  localparam logic [31:0] PH_K37 = 32'd252919152;
  localparam logic [31:0] PH_K11 = 32'd75192179;
  localparam logic [14:0] SIN_A  = 15'd25736;
  localparam logic [13:0] SIN_B  = 14'd10512;
  localparam logic [10:0] SIN_C  = 11'd1160;
  localparam logic [13:0] GAIN_ONE = 14'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GLOW  = 4'd0,
    REG_BLOOM = 4'd1,
    REG_MOIRE = 4'd2,
    REG_REFL  = 4'd3,
    REG_POL   = 4'd4,
    REG_COAT  = 4'd5,
    REG_INVW  = 4'd6,
    REG_INVH  = 4'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [2:0][CW-1:0] c;
    logic [15:0]        alpha;
    logic [31:0]        p1;
    logic [31:0]        p2;
    logic signed [38:0] nx;
    logic signed [38:0] ny;
  } s1_t;

  typedef struct packed {
    logic [2:0][CW-1:0] c;
    logic [15:0]        alpha;
    logic [1:0][14:0]   z;
    logic [1:0]         neg;
    logic [1:0][14:0]   z2;
    logic signed [56:0] rs;
  } s2_t;

  typedef struct packed {
    logic [2:0][CW-1:0] c;
    logic [15:0]        alpha;
    logic [1:0][14:0]   z;
    logic [1:0]         neg;
    logic [1:0][14:0]   z2;
    logic [1:0][10:0]   t;
    logic [12:0]        g12;
  } s3_t;

  typedef struct packed {
    logic [2:0][CW-1:0] c;
    logic [15:0]        alpha;
    logic [1:0][14:0]   z;
    logic [1:0]         neg;
    logic [1:0][14:0]   w;
    logic [12:0]        g2;
  } s4_t;

  typedef struct packed {
    logic [2:0][CW-1:0] c;
    logic [15:0]        alpha;
    logic [1:0][15:0]   smag;
    logic [1:0]         neg;
    logic [12:0]        refl;
  } s5_t;

  typedef struct packed {
    logic [2:0][CW-1:0] c;
    logic [15:0]        alpha;
    logic [16:0]        bmag;
    logic               bneg;
    logic [2:0][CW-1:0] add;
  } s6_t;

  typedef struct packed {
    logic [2:0][CW-1:0] c;
    logic [15:0]        alpha;
    logic [13:0]        fac;
    logic [2:0][CW-1:0] add;
  } s7_t;

  typedef struct packed {
    logic [2:0][CW-1:0] c;
    logic [15:0]        alpha;
  } col_t;

  // Q12 additive term to color format
  function automatic logic [CW-1:0] to_color(input logic [15:0] v);
    logic [47:0] t;
    t = ({32'd0, v} << COLOR_FRAC_BITS) + (48'd1 << (GAIN_FRAC - 1));
    return CW'(t >> GAIN_FRAC);
  endfunction

endpackage

// File: rtl/display_optics_composite.sv
// ----------------------------------------------------------------------------
// display_optics_composite
// Per-pixel final composite: glow and bloom add, moire gain, reflection
// highlight, polarizer darkening and anti-reflective tint.
// ----------------------------------------------------------------------------
// One pixel enters per clock unless the input is stalled, and its result
// leaves through a ten-stage pipeline; the depth is set by the chain of
// dependent multiplies of the quintic sine evaluation and the moire scaling
// that follows it. A stall from the output side only backs up the stages
// that hold pixels, so bubbles are squeezed out. Registers take effect for
// pixels accepted after the write; write them while no pixel is in flight.
`include "display_optics_composite_defines.svh"

module display_optics_composite (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [doc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [doc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [15:0]                     base_red_i,
  input  logic [15:0]                     base_green_i,
  input  logic [15:0]                     base_blue_i,
  input  logic [15:0]                     base_alpha_i,
  input  logic [15:0]                     glow_red_i,
  input  logic [15:0]                     glow_green_i,
  input  logic [15:0]                     glow_blue_i,
  input  logic [15:0]                     bloom_red_i,
  input  logic [15:0]                     bloom_green_i,
  input  logic [15:0]                     bloom_blue_i,
  input  logic [11:0]                     pixel_col_i,
  input  logic [11:0]                     pixel_row_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [15:0]                     out_red_o,
  output logic [15:0]                     out_green_o,
  output logic [15:0]                     out_blue_o,
  output logic [15:0]                     out_alpha_o
);
  import doc_pkg::*;

  // configuration
  logic [15:0] glow_gain_q, bloom_gain_q;
  logic [12:0] moire_q, pol_q, coat_q;
  logic [14:0] refl_q;
  logic [24:0] invw_q, invh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      glow_gain_q  <= '0;
      bloom_gain_q <= '0;
      moire_q      <= '0;
      refl_q       <= '0;
      pol_q        <= '0;
      coat_q       <= '0;
      invw_q       <= 25'd16777216;
      invh_q       <= 25'd16777216;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_GLOW:  glow_gain_q  <= cfg_data_i[15:0];
        REG_BLOOM: bloom_gain_q <= cfg_data_i[15:0];
        REG_MOIRE: moire_q      <= cfg_data_i[12:0];
        REG_REFL:  refl_q       <= cfg_data_i[14:0];
        REG_POL:   pol_q        <= cfg_data_i[12:0];
        REG_COAT:  coat_q       <= cfg_data_i[12:0];
        REG_INVW:  invw_q       <= cfg_data_i;
        REG_INVH:  invh_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // derived factors, registered from the configuration; first used in stage five
  logic [10:0] m15_q;
  logic [12:0] ra_q, pf_q, pfb_q;
  logic        pol_en_q;
  logic [8:0]  ca_q;
  logic [2:0][CW-1:0] tint_q;

  always_ff @(posedge clk_i) begin
    m15_q    <= 11'(({14'd0, moire_q} * 27'd9830 + 27'd32768) >> 16);
    ra_q     <= 13'(({14'd0, refl_q} * 29'd9830 + 29'd32768) >> 16);
    pf_q     <= 13'(14'd4096 - 14'(({1'b0, pol_q} + 14'd2) >> 2));
    pfb_q    <= 13'(({13'd0, pf_q} * 26'd4219 + 26'd2048) >> 12);
    pol_en_q <= (pol_q != '0);
    ca_q     <= 9'(({13'd0, coat_q} * 26'd1966 + 26'd32768) >> 16);
    tint_q[0] <= to_color(16'(({13'd0, ca_q} * 22'd1638 + 22'd2048) >> 12));
    tint_q[1] <= to_color({7'd0, ca_q});
    tint_q[2] <= to_color(16'(({13'd0, ca_q} * 22'd3277 + 22'd2048) >> 12));
  end

  // stage flow control: a stage advances when empty or when the next one does
  logic [NSTG-1:0] v_q, en;

  always_comb begin
    en[NSTG-1] = !v_q[NSTG-1] || !out_stall_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = v_q[NSTG-1];

  // stage 1: glow and bloom add, sine phases, normalized offsets
  s1_t s1_d, s1_q;
  logic [2:0][15:0] base_a, glow_a, bloom_a;
  logic [32:0] pg, pb;
  logic [37:0] px, py;

  always_comb begin
    base_a  = {base_blue_i, base_green_i, base_red_i};
    glow_a  = {glow_blue_i, glow_green_i, glow_red_i};
    bloom_a = {bloom_blue_i, bloom_green_i, bloom_red_i};
    pg = '0;
    pb = '0;
    for (int k = 0; k < 3; k++) begin
      pg = {17'd0, glow_a[k]} * {17'd0, glow_gain_q} + 33'd2048;
      pb = {17'd0, bloom_a[k]} * {17'd0, bloom_gain_q} + 33'd2048;
      s1_d.c[k] = CW'(base_a[k]) + CW'(pg >> GAIN_FRAC) + CW'(pb >> GAIN_FRAC);
    end
    s1_d.alpha = base_alpha_i;
    // coordinates are 12 bits and so already below MAX_DIM
    s1_d.p1 = {20'd0, pixel_col_i} * PH_K37 + {20'd0, pixel_row_i} * PH_K11;
    s1_d.p2 = {20'd0, pixel_col_i} * PH_K11 - {20'd0, pixel_row_i} * PH_K37;
    px = 38'({pixel_col_i, 1'b1}) * 38'(invw_q);
    py = 38'({pixel_row_i, 1'b1}) * 38'(invh_q);
    s1_d.nx = $signed({1'b0, px}) - 39'sd16777216;
    s1_d.ny = $signed({1'b0, py}) - 39'sd16777216;
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) s1_q <= s1_d;
  end

  // stage 2: table index, quarter-wave fold, z squared; reflection sum
  s2_t s2_d, s2_q;
  logic [1:0][31:0] ph;
  logic [SIN_IDX_W-1:0] sidx;
  logic signed [15:0] sr;
  logic signed [16:0] sf;
  logic [29:0] zz;

  always_comb begin
    s2_d.c     = s1_q.c;
    s2_d.alpha = s1_q.alpha;
    ph = {s1_q.p2, s1_q.p1};
    sidx = '0;
    sr = '0;
    sf = '0;
    zz = '0;
    for (int j = 0; j < 2; j++) begin
      sidx = SIN_IDX_W'((ph[j] + (32'd1 << (31 - SIN_IDX_W))) >> (32 - SIN_IDX_W));
      sr = $signed(16'({sidx, {(16 - SIN_IDX_W){1'b0}}}));
      if (sr > 16'sd16384) begin
        sf = 17'sd32768 - 17'(sr);
      end else if (sr < -16'sd16384) begin
        sf = -17'sd32768 - 17'(sr);
      end else begin
        sf = 17'(sr);
      end
      s2_d.neg[j] = sf[16];
      s2_d.z[j]   = sf[16] ? 15'(-sf) : 15'(sf);
      zz = {15'd0, s2_d.z[j]} * {15'd0, s2_d.z[j]};
      s2_d.z2[j]  = 15'((zz + 30'd8192) >> 14);
    end
    s2_d.rs = 57'(s1_q.nx) * 57'sd52429 + 57'(s1_q.ny) * 57'sd39322;
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) s2_q <= s2_d;
  end

  // stage 3: inner sine term; reflection gradient clamp
  s3_t s3_d, s3_q;
  logic [56:0] rmag;
  logic [40:0] rrnd;
  logic signed [56:0] gsum;
  logic [25:0] gcl;

  always_comb begin
    s3_d.c     = s2_q.c;
    s3_d.alpha = s2_q.alpha;
    s3_d.z     = s2_q.z;
    s3_d.neg   = s2_q.neg;
    s3_d.z2    = s2_q.z2;
    for (int j = 0; j < 2; j++) begin
      s3_d.t[j] = 11'(({11'd0, s2_q.z2[j]} * 26'(SIN_C) + 26'd8192) >> 14);
    end
    rmag = s2_q.rs[56] ? 57'(-s2_q.rs) : 57'(s2_q.rs);
    rrnd = 41'((rmag + 57'd32768) >> 16);
    gsum = 57'sd16777216 + (s2_q.rs[56] ? -$signed(57'(rrnd)) : $signed(57'(rrnd)));
    if (gsum < 57'sd0) begin
      gcl = '0;
    end else if (gsum > 57'sd33554432) begin
      gcl = 26'd33554432;
    end else begin
      gcl = 26'(gsum);
    end
    s3_d.g12 = 13'((gcl + 26'd4096) >> 13);
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) s3_q <= s3_d;
  end

  // stage 4: outer sine term; gradient squared
  s4_t s4_d, s4_q;
  logic [28:0] vp;
  logic [14:0] vv;

  always_comb begin
    s4_d.c     = s3_q.c;
    s4_d.alpha = s3_q.alpha;
    s4_d.z     = s3_q.z;
    s4_d.neg   = s3_q.neg;
    vp = '0;
    vv = '0;
    for (int j = 0; j < 2; j++) begin
      vp = 29'(SIN_B - 14'(s3_q.t[j])) * 29'(s3_q.z2[j]) + 29'd8192;
      vv = 15'(vp >> 14);
      s4_d.w[j] = SIN_A - vv;
    end
    s4_d.g2 = 13'(({13'd0, s3_q.g12} * {13'd0, s3_q.g12} + 26'd2048) >> 12);
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) s4_q <= s4_d;
  end

  // stage 5: sine magnitudes; reflection amount
  s5_t s5_d, s5_q;

  always_comb begin
    s5_d.c     = s4_q.c;
    s5_d.alpha = s4_q.alpha;
    s5_d.neg   = s4_q.neg;
    for (int j = 0; j < 2; j++) begin
      s5_d.smag[j] = 16'(({15'd0, s4_q.z[j]} * {15'd0, s4_q.w[j]} + 30'd8192) >> 14);
    end
    s5_d.refl = 13'(({13'd0, ra_q} * {13'd0, s4_q.g2} + 26'd2048) >> 12);
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) s5_q <= s5_d;
  end

  // stage 6: sine product as sign and magnitude; highlight terms
  s6_t s6_d, s6_q;

  always_comb begin
    s6_d.c     = s5_q.c;
    s6_d.alpha = s5_q.alpha;
    s6_d.bmag  = 17'(({16'd0, s5_q.smag[0]} * {16'd0, s5_q.smag[1]} + 32'd8192) >> 14);
    s6_d.bneg  = s5_q.neg[0] ^ s5_q.neg[1];
    s6_d.add[0] = to_color({3'd0, s5_q.refl});
    s6_d.add[1] = s6_d.add[0];
    s6_d.add[2] = to_color(16'(({13'd0, s5_q.refl} * 26'd4506 + 26'd2048) >> 12));
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) s6_q <= s6_d;
  end

  // stage 7: moire factor, rounded on the magnitude
  s7_t s7_d, s7_q;
  logic [13:0] tmag;

  always_comb begin
    s7_d.c     = s6_q.c;
    s7_d.alpha = s6_q.alpha;
    s7_d.add   = s6_q.add;
    tmag = 14'(({17'd0, m15_q} * {11'd0, s6_q.bmag} + 28'd8192) >> 14);
    s7_d.fac = s6_q.bneg ? GAIN_ONE - tmag : GAIN_ONE + tmag;
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) s7_q <= s7_d;
  end

  // stage 8: moire scale and highlight add
  col_t s8_d, s8_q;

  always_comb begin
    s8_d.alpha = s7_q.alpha;
    for (int k = 0; k < 3; k++) begin
      s8_d.c[k] = CW'(({14'd0, s7_q.c[k]} * {24'd0, s7_q.fac} + 38'd2048) >> GAIN_FRAC)
                + s7_q.add[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[7]) s8_q <= s8_d;
  end

  // stage 9: polarizer, blue gets the cool tint factor; bypass when off
  col_t s9_d, s9_q;
  logic [12:0] pmul;

  always_comb begin
    s9_d = s8_q;
    pmul = '0;
    if (pol_en_q) begin
      for (int k = 0; k < 3; k++) begin
        pmul = (k == 2) ? pfb_q : pf_q;
        s9_d.c[k] = CW'(({13'd0, s8_q.c[k]} * {24'd0, pmul} + 37'd2048) >> GAIN_FRAC);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[8]) s9_q <= s9_d;
  end

  // stage 10: tint add and saturation into the output register
  logic [3:0][15:0] o_d, o_q;
  logic [CW:0] osum;

  always_comb begin
    osum = '0;
    for (int k = 0; k < 3; k++) begin
      osum = {1'b0, s9_q.c[k]} + {1'b0, tint_q[k]};
      o_d[k] = (osum > (CW+1)'(16'hFFFF)) ? 16'hFFFF : osum[15:0];
    end
    o_d[3] = s9_q.alpha;
  end

  always_ff @(posedge clk_i) begin
    if (en[9]) o_q <= o_d;
  end

  assign out_red_o   = o_q[0];
  assign out_green_o = o_q[1];
  assign out_blue_o  = o_q[2];
  assign out_alpha_o = o_q[3];

  `DOC_ASSERT(a_stall_only_full, !in_stall_o || (&v_q), "input stalled with a free stage")
  `DOC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "result dropped in stall")
  `DOC_ASSERT(a_grad_range, !v_q[2] || (s3_q.g12 <= 13'd4096), "gradient out of range")
  `DOC_ASSERT(a_fac_positive, !v_q[6] || (s7_q.fac != 14'd0), "moire factor is zero")

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// Display optics composite testbench
// Streams pixels through the compositor under several register settings,
// with bursty input and a stalling output. A scoreboard predicts every
// composited pixel in fixed point and compares it field by field, in order.
// ----------------------------------------------------------------------------
import doc_pkg::*;

typedef struct {
  bit [15:0] base [4];
  bit [15:0] glow [3];
  bit [15:0] bloom [3];
  bit [11:0] col;
  bit [11:0] row;
} pixel_t;

typedef struct {
  bit [15:0] red;
  bit [15:0] green;
  bit [15:0] blue;
  bit [15:0] alpha;
} color_t;

class composite_scoreboard;
  bit [24:0] regs [8];
  color_t    pending_colors [$];
  int        fails;

  function new();
    foreach (regs[i]) regs[i] = '0;
    regs[REG_INVW] = 25'd1 << 24;
    regs[REG_INVH] = 25'd1 << 24;
    fails = 0;
  endfunction

  function void set_reg(int idx, bit [24:0] val);
    case (idx)
      REG_GLOW, REG_BLOOM:         regs[idx] = val & 25'hFFFF;
      REG_MOIRE, REG_POL, REG_COAT: regs[idx] = val & 25'h1FFF;
      REG_REFL:                    regs[idx] = val & 25'h7FFF;
      REG_INVW, REG_INVH:          regs[idx] = val;
      default: ;
    endcase
  endfunction

  static function bit [63:0] rnd(bit [63:0] v, int n);
    return (v + (64'd1 << (n - 1))) >> n;
  endfunction

  static function longint srnd(longint v, int n);
    if (v < 0) return -longint'(rnd(-v, n));
    return longint'(rnd(v, n));
  endfunction

  static function bit [63:0] to_color(bit [63:0] v);
    return rnd(v << COLOR_FRAC_BITS, GAIN_FRAC);
  endfunction

  // Q14 sine of a Q0.32 turn phase through the quarter-wave quintic
  static function longint sine_q14(bit [31:0] phase);
    bit [63:0] idx;
    longint r, z, z2, t, v, w, s;
    bit neg;
    idx = ((64'(phase) * SINE_TABLE_DEPTH) + 64'h8000_0000) >> 32;
    idx = idx % SINE_TABLE_DEPTH;
    r = longint'((idx * 65536) / SINE_TABLE_DEPTH);
    if (r >= 32768) r -= 65536;
    if (r > 16384) r = 32768 - r;
    else if (r < -16384) r = -32768 - r;
    neg = r < 0;
    z = neg ? -r : r;
    z2 = longint'(rnd(z * z, 14));
    t = longint'(rnd(1160 * z2, 14));
    v = longint'(rnd((10512 - t) * z2, 14));
    w = 25736 - v;
    s = longint'(rnd(z * w, 14));
    return neg ? -s : s;
  endfunction

  function color_t composite(pixel_t p);
    bit [63:0] c [3];
    bit [63:0] x, y, m15, fac, g12, g2, ra, refl, f, fb, a, add0;
    bit [31:0] p1, p2;
    longint beat, term, nx, ny, g;
    color_t res;
    for (int k = 0; k < 3; k++)
      c[k] = p.base[k] + rnd(64'(p.glow[k]) * regs[REG_GLOW], GAIN_FRAC)
           + rnd(64'(p.bloom[k]) * regs[REG_BLOOM], GAIN_FRAC);
    x = 64'(p.col);
    y = 64'(p.row);
    if (regs[REG_MOIRE] != 0) begin
      p1 = 32'(x * PH_K37 + y * PH_K11);
      p2 = 32'(x * PH_K11 - y * PH_K37);
      beat = srnd(sine_q14(p1) * sine_q14(p2), 14);
      m15 = rnd(regs[REG_MOIRE] * 64'd9830, 16);
      term = srnd(longint'(m15) * beat, 14);
      fac = 64'(longint'(4096) + term);
      for (int k = 0; k < 3; k++) c[k] = rnd(c[k] * fac, GAIN_FRAC);
    end
    if (regs[REG_REFL] != 0) begin
      nx = longint'((2 * x + 1) * regs[REG_INVW]) - (longint'(1) << 24);
      ny = longint'((2 * y + 1) * regs[REG_INVH]) - (longint'(1) << 24);
      g = (longint'(1) << 24) + srnd(nx * 52429 + ny * 39322, 16);
      if (g < 0) g = 0;
      if (g > (longint'(1) << 25)) g = longint'(1) << 25;
      g12 = rnd(64'(g), 13);
      g2 = rnd(g12 * g12, GAIN_FRAC);
      ra = rnd(regs[REG_REFL] * 64'd9830, 16);
      refl = rnd(ra * g2, GAIN_FRAC);
      add0 = to_color(refl);
      c[0] += add0;
      c[1] += add0;
      c[2] += to_color(rnd(refl * 4506, GAIN_FRAC));
    end
    if (regs[REG_POL] != 0) begin
      f = 4096 - rnd(regs[REG_POL], 2);
      fb = rnd(f * 4219, GAIN_FRAC);
      c[0] = rnd(c[0] * f, GAIN_FRAC);
      c[1] = rnd(c[1] * f, GAIN_FRAC);
      c[2] = rnd(c[2] * fb, GAIN_FRAC);
    end
    if (regs[REG_COAT] != 0) begin
      a = rnd(regs[REG_COAT] * 64'd1966, 16);
      c[0] += to_color(rnd(a * 1638, GAIN_FRAC));
      c[1] += to_color(a);
      c[2] += to_color(rnd(a * 3277, GAIN_FRAC));
    end
    res.red   = c[0] > 65535 ? 16'hFFFF : c[0][15:0];
    res.green = c[1] > 65535 ? 16'hFFFF : c[1][15:0];
    res.blue  = c[2] > 65535 ? 16'hFFFF : c[2][15:0];
    res.alpha = p.base[3];
    return res;
  endfunction

  function void note_pixel(pixel_t p);
    pending_colors.push_back(composite(p));
  endfunction

  function void check_result(color_t got);
    color_t want;
    if (pending_colors.size() == 0) begin
      $error("composited pixel with none pending");
      fails++;
      return;
    end
    want = pending_colors.pop_front();
    if (got.red != want.red) begin
      $error("out_red expected %0h actual %0h", want.red, got.red);
      fails++;
    end
    if (got.green != want.green) begin
      $error("out_green expected %0h actual %0h", want.green, got.green);
      fails++;
    end
    if (got.blue != want.blue) begin
      $error("out_blue expected %0h actual %0h", want.blue, got.blue);
      fails++;
    end
    if (got.alpha != want.alpha) begin
      $error("out_alpha expected %0h actual %0h", want.alpha, got.alpha);
      fails++;
    end
  endfunction
endclass

module testbench;
  localparam int IDLE_LIMIT = 4000;
  localparam int NUM_PHASES = 9;
  localparam int PIXELS_PER_PHASE = 150;
  localparam int DRAIN_CYCLES = 2 * NSTG;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(REG_INVH) + 1'b1;

  logic        clk_i, rst_ni;
  logic        cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic        in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  logic [15:0] base_red_i, base_green_i, base_blue_i, base_alpha_i;
  logic [15:0] glow_red_i, glow_green_i, glow_blue_i;
  logic [15:0] bloom_red_i, bloom_green_i, bloom_blue_i;
  logic [11:0] pixel_col_i, pixel_row_i;
  logic [15:0] out_red_o, out_green_o, out_blue_o, out_alpha_o;

  composite_scoreboard sb = new();
  int idle_cycles;
  int burst_left;

  display_optics_composite dut (.*);

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
  end

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    cfg_we_i <= 1'b0;
    cfg_idx_i <= REG_GLOW;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    {base_red_i, base_green_i, base_blue_i, base_alpha_i} <= '0;
    {glow_red_i, glow_green_i, glow_blue_i} <= '0;
    {bloom_red_i, bloom_green_i, bloom_blue_i} <= '0;
    pixel_col_i <= '0;
    pixel_row_i <= '0;
  end

  // Output side: one long hold-off first so the pipeline backs up, then
  // segments of free flow, light and heavy stalling.
  initial begin
    int pct, len;
    out_stall_i <= 1'b0;
    @(posedge clk_i);
    wait (rst_ni);
    repeat (150) begin
      out_stall_i <= 1'b1;
      @(posedge clk_i);
    end
    forever begin
      case ($urandom_range(0, 3))
        0: pct = 0;
        1: pct = 25;
        2: pct = 70;
        default: pct = 100;
      endcase
      len = (pct == 100) ? $urandom_range(20, 80) : $urandom_range(20, 200);
      repeat (len) begin
        out_stall_i <= ($urandom_range(0, 99) < pct);
        @(posedge clk_i);
      end
    end
  end

  // Check results and watch for a hang.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        sb.check_result('{out_red_o, out_green_o, out_blue_o, out_alpha_o});
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  task automatic write_regs(bit [24:0] vals [8], bit with_spare);
    for (int i = 0; i < 8; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= cfg_reg_e'(i);
      cfg_data_i <= vals[i];
      sb.set_reg(i, vals[i]);
      @(posedge clk_i);
    end
    if (with_spare) begin
      // out-of-range index: must leave every register alone
      cfg_idx_i <= REG_SPARE;
      cfg_data_i <= CFG_DATA_W'($urandom());
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_pixel(pixel_t p);
    if (burst_left == 0) begin
      if ($urandom_range(0, 2) == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    {base_red_i, base_green_i, base_blue_i, base_alpha_i} <=
      {p.base[0], p.base[1], p.base[2], p.base[3]};
    {glow_red_i, glow_green_i, glow_blue_i} <= {p.glow[0], p.glow[1], p.glow[2]};
    {bloom_red_i, bloom_green_i, bloom_blue_i} <= {p.bloom[0], p.bloom[1], p.bloom[2]};
    pixel_col_i <= p.col;
    pixel_row_i <= p.row;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_pixel(p);
  endtask

  function automatic pixel_t edge_pixel(int n);
    pixel_t p;
    bit [15:0] v;
    v = (n % 3 == 0) ? 16'h0000 : (n % 3 == 1) ? 16'hFFFF : 16'h1000;
    foreach (p.base[i]) p.base[i] = (n % 4 == 3) ? 16'hFFFF - v : v;
    foreach (p.glow[i]) p.glow[i] = v;
    foreach (p.bloom[i]) p.bloom[i] = (n % 2) ? 16'hFFFF : 16'h0000;
    p.col = (n % 2) ? 12'hFFF : 12'h000;
    p.row = (n % 4 < 2) ? 12'h000 : 12'hFFF;
    if (n >= 8) begin
      p.col = 12'($urandom());
      p.row = 12'($urandom());
    end
    return p;
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t p;
    bit mild;
    mild = 1'($urandom_range(0, 1));
    foreach (p.base[i]) p.base[i] = mild ? 16'($urandom_range(0, 8192)) : 16'($urandom());
    foreach (p.glow[i]) p.glow[i] = mild ? 16'($urandom_range(0, 4096)) : 16'($urandom());
    foreach (p.bloom[i]) p.bloom[i] = mild ? 16'($urandom_range(0, 4096)) : 16'($urandom());
    p.base[3] = 16'($urandom());
    p.col = 12'($urandom());
    p.row = 12'($urandom());
    return p;
  endfunction

  function automatic bit [24:0] pick_inverse();
    case ($urandom_range(0, 3))
      0: return 25'($urandom_range(0, 25'h1FFFFFF));
      1: return 25'd0;
      default: return 25'((32'd1 << 24) / $urandom_range(16, 4096));
    endcase
  endfunction

  initial begin
    bit [24:0] vals [8];
    idle_cycles = 0;
    burst_left = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        case (ph)
          1: vals = '{25'hFFFF, 25'hFFFF, 25'h1FFF, 25'h7FFF, 25'h1FFF, 25'h1FFF,
                      25'h1FFFFFF, 25'h1FFFFFF};
          2: vals = '{default: 25'd0};
          3: vals = '{25'd4096, 25'd4096, 25'd4096, 25'd16384, 25'd4096, 25'd4096,
                      25'd1 << 24, 25'd1 << 24};
          default: begin
            foreach (vals[i])
              vals[i] = ($urandom_range(0, 3) == 0) ? 25'd0 : 25'($urandom());
            vals[REG_INVW] = pick_inverse();
            vals[REG_INVH] = pick_inverse();
          end
        endcase
        write_regs(vals, ph >= 4);
      end
      for (int n = 0; n < PIXELS_PER_PHASE; n++) begin
        if (ph < 4 && n < 12) send_pixel(edge_pixel(n));
        else send_pixel(random_pixel());
      end
      in_valid_i <= 1'b0;
      burst_left = 0;
      while (sb.pending_colors.size() > 0) @(posedge clk_i);
      repeat (DRAIN_CYCLES) @(posedge clk_i);
    end
    if (sb.fails == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end
endmodule

// File: display_optics_composite.f
+incdir+rtl
rtl/doc_pkg.sv
rtl/display_optics_composite.sv
verif/testbench.sv
